/* sv/ffsa_pkg.sv */
// Shared types and constants of the first-fit segment allocator.
// Used by ffsa_ctrl, ffsa_datapath and first_fit_segment_allocator_core.
package ffsa_pkg;

	localparam int MAX_SEGMENTS = 64;
	localparam int ADDR_BITS    = 16;
	localparam int LEN_BITS     = ADDR_BITS + 1;
	localparam int IDX_BITS     = $clog2(MAX_SEGMENTS);
	localparam int CNT_BITS     = IDX_BITS + 1;

	localparam logic [LEN_BITS-1:0] POOL_MAX = LEN_BITS'(1) << ADDR_BITS;
	localparam logic [CNT_BITS-1:0] CNT_MAX  = CNT_BITS'(MAX_SEGMENTS);

	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_NOFIT    = 3'd1;
	localparam logic [2:0] ST_NOTFOUND = 3'd2;
	localparam logic [2:0] ST_FULL     = 3'd3;
	localparam logic [2:0] ST_ZERO     = 3'd4;

	localparam logic [1:0] REQ_ALLOC  = 2'd0;
	localparam logic [1:0] REQ_FREE   = 2'd1;
	localparam logic [1:0] REQ_RESIZE = 2'd2;

	typedef struct packed {
		logic                 free;
		logic [LEN_BITS-1:0]  len;
		logic [ADDR_BITS-1:0] off;
	} seg_t;

	typedef enum logic [4:0] {
		S_INIT, S_IDLE, S_DISPATCH, S_FIND_RD, S_FIND_EV, S_REL, S_RN_CHK, S_RN_EV,
		S_RP_CHK, S_RP_EV, S_MV_CHK, S_MV_WR, S_FIT_RD, S_FIT_EV, S_FIT_GOT,
		S_FIT_END, S_SU_CHK, S_SU_WR, S_SP_TAIL, S_SP_HEAD, S_RS_CHK, S_GR_CHK,
		S_GR_EV, S_GR_POST, S_MOVE, S_DONE
	} state_t;

	typedef enum logic [2:0] {OP_ALLOC, OP_FREE, OP_RESIZE, OP_MOVE_FIT, OP_MOVE_FREE} op_t;

	typedef enum logic [2:0] {P_HOLD, P_ZERO, P_INC, P_DEC, P_IDX1, P_IDX2, P_CNT} ptr_op_t;

	typedef enum logic [1:0] {R_PTR, R_PTRM1, R_IDXP1, R_IDXM1} rd_sel_t;

	typedef enum logic [2:0] {
		W_NONE, W_INIT, W_PTRM1_RD, W_PTR_RD, W_TAIL, W_HEAD, W_W, W_PREV
	} wr_op_t;

	typedef enum logic [1:0] {C_HOLD, C_ONE, C_INC, C_DEC} cnt_op_t;

	typedef enum logic [1:0] {WO_HOLD, WO_LD, WO_FREE, WO_ABSORB} w_op_t;

	typedef struct packed {
		logic       start;
		ptr_op_t    ptr_op;
		rd_sel_t    rd_sel;
		wr_op_t     wr_op;
		cnt_op_t    cnt_op;
		w_op_t      w_op;
		logic       save_old;
		logic       res_addr;
		logic       res_woff;
		logic       set_reloc;
		logic       finish;
		logic [2:0] status;
	} dp_cmd_t;

	typedef struct packed {
		logic [1:0] req_type;
		logic       size_zero;
		logic       hit_find;
		logic       hit_fit;
		logic       ptr_lt_cnt;
		logic       idx1_lt_cnt;
		logic       idx_nz;
		logic       ptr_gt_idx1;
		logic       rd_free;
		logic       w_free;
		logic       w_eq;
		logic       w_gt;
		logic       cnt_full;
		logic       absorb_ok;
	} dp_stat_t;

endpackage

/* sv/first_fit_segment_allocator_core.sv */
// Top level of the first-fit segment allocator with coalescing.
// Depends on ffsa_pkg, ffsa_ctrl and ffsa_datapath.
//
// Usage:
//   Requests: drive req_type, req_address and req_size with start high; the request
//   is taken at a rising edge where busy and cfg_we are low. busy stays high until the result
//   has been issued.
//   Results: done is high for exactly one cycle with status, result_address,
//   relocated, copy_from and copy_length; the receiver cannot hold a result off,
//   so it must take every transfer in that cycle. The result ports keep their
//   value until the next result.
//   Configuration: cfg_we with cfg_wdata writes pool_size; the user must write it
//   only while busy is low, which the block itself does not enforce. Written while idle,
//   the table is reinitialized to one free segment in the following cycle.
//   Table: the segment table sits in a memory with one write port and a registered
//   read port. A scan reads and then evaluates one entry at a time, and a split or
//   merge shifts the entries behind it one by one, so a request takes longer the
//   more entries it scans and shifts.
//   Reset: the pool is 65536 bytes; the init state writes one free segment to the
//   table, and busy falls as the controller then enters idle.
module first_fit_segment_allocator_core import ffsa_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  logic [1:0]           req_type,
	input  logic [ADDR_BITS-1:0] req_address,
	input  logic [LEN_BITS-1:0]  req_size,
	output logic                 done,
	output logic [2:0]           status,
	output logic [ADDR_BITS-1:0] result_address,
	output logic                 relocated,
	output logic [ADDR_BITS-1:0] copy_from,
	output logic [LEN_BITS-1:0]  copy_length,
	input  logic                 cfg_we,
	input  logic [LEN_BITS-1:0]  cfg_wdata
);

	dp_cmd_t  cmd;
	dp_stat_t stat;

	ffsa_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.cfg_we (cfg_we),
		.stat   (stat),
		.busy   (busy),
		.cmd    (cmd)
	);

	ffsa_datapath u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.stat           (stat),
		.cfg_we         (cfg_we),
		.cfg_wdata      (cfg_wdata),
		.req_type       (req_type),
		.req_address    (req_address),
		.req_size       (req_size),
		.done           (done),
		.status         (status),
		.result_address (result_address),
		.relocated      (relocated),
		.copy_from      (copy_from),
		.copy_length    (copy_length)
	);

	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result issued without a request in flight");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted request did not raise busy");

	a_status_legal: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> status <= ST_ZERO)
		else $error("illegal status code");

	a_reloc_ok: assert property (@(posedge clk) disable iff (!arst_n)
		relocated |-> status == ST_OK)
		else $error("relocation reported with failing status");

endmodule

/* sv/ffsa_datapath.sv */
// Datapath of the allocator: segment table memory, count, pointers and result registers.
// Depends on ffsa_pkg; driven by commands from ffsa_ctrl.
module ffsa_datapath import ffsa_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  dp_cmd_t              cmd,
	output dp_stat_t             stat,
	input  logic                 cfg_we,
	input  logic [LEN_BITS-1:0]  cfg_wdata,
	input  logic [1:0]           req_type,
	input  logic [ADDR_BITS-1:0] req_address,
	input  logic [LEN_BITS-1:0]  req_size,
	output logic                 done,
	output logic [2:0]           status,
	output logic [ADDR_BITS-1:0] result_address,
	output logic                 relocated,
	output logic [ADDR_BITS-1:0] copy_from,
	output logic [LEN_BITS-1:0]  copy_length
);

	seg_t                 mem_q [MAX_SEGMENTS];
	seg_t                 rd_q;
	seg_t                 w_q;
	seg_t                 wr_data;
	logic                 wr_en;
	logic [IDX_BITS-1:0]  wr_addr;
	logic [IDX_BITS-1:0]  rd_addr;
	logic [IDX_BITS-1:0]  idx_q;
	logic [CNT_BITS-1:0]  ptr_q;
	logic [CNT_BITS-1:0]  cnt_q;
	logic [CNT_BITS-1:0]  idx_p1;
	logic [LEN_BITS-1:0]  pool_q;
	logic [1:0]           type_q;
	logic [ADDR_BITS-1:0] addr_q;
	logic [LEN_BITS-1:0]  size_q;
	logic [LEN_BITS-1:0]  old_q;
	logic [ADDR_BITS-1:0] res_q;
	logic                 reloc_q;
	logic [ADDR_BITS-1:0] from_q;
	logic [LEN_BITS-1:0]  clen_q;
	logic [LEN_BITS:0]    sum_next;
	logic                 ok;

	assign idx_p1   = {1'b0, idx_q} + CNT_BITS'(1);
	assign sum_next = {1'b0, w_q.len} + {1'b0, rd_q.len};
	assign ok       = (cmd.status == ST_OK);

	always_comb begin
		case (cmd.rd_sel)
			R_PTR:   rd_addr = ptr_q[IDX_BITS-1:0];
			R_PTRM1: rd_addr = IDX_BITS'(ptr_q - CNT_BITS'(1));
			R_IDXP1: rd_addr = idx_p1[IDX_BITS-1:0];
			R_IDXM1: rd_addr = idx_q - IDX_BITS'(1);
			default: rd_addr = ptr_q[IDX_BITS-1:0];
		endcase
	end

	always_comb begin
		wr_en   = 1'b1;
		wr_addr = idx_q;
		wr_data = w_q;
		case (cmd.wr_op)
			W_INIT: begin
				wr_addr = '0;
				wr_data = '{free: 1'b1, len: pool_q, off: '0};
			end
			W_PTRM1_RD: begin
				wr_addr = IDX_BITS'(ptr_q - CNT_BITS'(1));
				wr_data = rd_q;
			end
			W_PTR_RD: begin
				wr_addr = ptr_q[IDX_BITS-1:0];
				wr_data = rd_q;
			end
			W_TAIL: begin
				wr_addr = idx_p1[IDX_BITS-1:0];
				wr_data = '{free: 1'b1, len: w_q.len - size_q,
					off: w_q.off + size_q[ADDR_BITS-1:0]};
			end
			W_HEAD: begin
				wr_data = '{free: 1'b0, len: size_q, off: w_q.off};
			end
			W_W: begin
				wr_data = w_q;
			end
			W_PREV: begin
				wr_addr = idx_q - IDX_BITS'(1);
				wr_data = '{free: 1'b1, len: sum_next[LEN_BITS-1:0], off: rd_q.off};
			end
			default: begin
				wr_en = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_q <= mem_q[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pool_q <= POOL_MAX;
			cnt_q  <= CNT_BITS'(1);
			done   <= 1'b0;
		end else begin
			if (cfg_we) begin
				if (cfg_wdata == '0) begin
					pool_q <= LEN_BITS'(1);
				end else if (cfg_wdata > POOL_MAX) begin
					pool_q <= POOL_MAX;
				end else begin
					pool_q <= cfg_wdata;
				end
			end
			case (cmd.cnt_op)
				C_ONE:   cnt_q <= CNT_BITS'(1);
				C_INC:   cnt_q <= cnt_q + CNT_BITS'(1);
				C_DEC:   cnt_q <= cnt_q - CNT_BITS'(1);
				default: cnt_q <= cnt_q;
			endcase
			done <= cmd.finish;
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.ptr_op)
			P_ZERO:  ptr_q <= '0;
			P_INC:   ptr_q <= ptr_q + CNT_BITS'(1);
			P_DEC:   ptr_q <= ptr_q - CNT_BITS'(1);
			P_IDX1:  ptr_q <= idx_p1;
			P_IDX2:  ptr_q <= idx_p1 + CNT_BITS'(1);
			P_CNT:   ptr_q <= cnt_q;
			default: ptr_q <= ptr_q;
		endcase
		case (cmd.w_op)
			WO_LD: begin
				w_q   <= rd_q;
				idx_q <= ptr_q[IDX_BITS-1:0];
			end
			WO_FREE:   w_q.free <= 1'b1;
			WO_ABSORB: w_q.len  <= sum_next[LEN_BITS-1:0];
			default:   w_q      <= w_q;
		endcase
		if (cmd.start) begin
			type_q  <= req_type;
			addr_q  <= req_address;
			size_q  <= req_size;
			res_q   <= '0;
			reloc_q <= 1'b0;
			from_q  <= '0;
			clen_q  <= '0;
		end
		if (cmd.save_old) begin
			old_q <= w_q.len;
		end
		if (cmd.res_addr) begin
			res_q <= addr_q;
		end
		if (cmd.res_woff) begin
			res_q <= w_q.off;
		end
		if (cmd.set_reloc) begin
			reloc_q <= 1'b1;
			from_q  <= addr_q;
			clen_q  <= old_q;
		end
		if (cmd.finish) begin
			status         <= cmd.status;
			result_address <= ok ? res_q : '0;
			relocated      <= ok & reloc_q;
			copy_from      <= ok ? from_q : '0;
			copy_length    <= ok ? clen_q : '0;
		end
	end

	always_comb begin
		stat.req_type    = type_q;
		stat.size_zero   = (size_q == '0);
		stat.hit_find    = (rd_q.off == addr_q);
		stat.hit_fit     = rd_q.free && (rd_q.len >= size_q);
		stat.ptr_lt_cnt  = (ptr_q < cnt_q);
		stat.idx1_lt_cnt = (idx_p1 < cnt_q);
		stat.idx_nz      = (idx_q != '0);
		stat.ptr_gt_idx1 = (ptr_q > idx_p1);
		stat.rd_free     = rd_q.free;
		stat.w_free      = w_q.free;
		stat.w_eq        = (w_q.len == size_q);
		stat.w_gt        = (w_q.len > size_q);
		stat.cnt_full    = (cnt_q >= CNT_MAX);
		stat.absorb_ok   = rd_q.free && (sum_next >= {1'b0, size_q});
	end

endmodule

/* sv/ffsa_ctrl.sv */
// Controller state machine of the allocator: sequences scans, splits, merges and shifts.
// Depends on ffsa_pkg; commands ffsa_datapath.
module ffsa_ctrl import ffsa_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	input  logic     cfg_we,
	input  dp_stat_t stat,
	output logic     busy,
	output dp_cmd_t  cmd
);

	state_t state_q, state_d, ret_q, ret_d;
	op_t    op_q, op_d;

	assign busy = (state_q != S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
			ret_q   <= S_DONE;
			op_q    <= OP_ALLOC;
		end else begin
			state_q <= state_d;
			ret_q   <= ret_d;
			op_q    <= op_d;
		end
	end

	always_comb begin
		state_d = state_q;
		ret_d   = ret_q;
		op_d    = op_q;
		case (state_q)
			S_INIT: state_d = S_IDLE;
			S_IDLE: begin
				if (cfg_we) begin
					state_d = S_INIT;
				end else if (start) begin
					state_d = S_DISPATCH;
				end
			end
			S_DISPATCH: begin
				state_d = S_IDLE;
				case (stat.req_type)
					REQ_ALLOC: begin
						op_d = OP_ALLOC;
						if (!stat.size_zero) begin
							state_d = S_FIT_RD;
						end
					end
					REQ_FREE: begin
						op_d    = OP_FREE;
						state_d = S_FIND_RD;
					end
					REQ_RESIZE: begin
						op_d = OP_RESIZE;
						if (!stat.size_zero) begin
							state_d = S_FIND_RD;
						end
					end
					default: state_d = S_IDLE;
				endcase
			end
			S_FIND_RD: state_d = stat.ptr_lt_cnt ? S_FIND_EV : S_IDLE;
			S_FIND_EV: begin
				if (!stat.hit_find) begin
					state_d = S_FIND_RD;
				end else if (op_q == OP_RESIZE) begin
					state_d = S_RS_CHK;
				end else begin
					state_d = S_REL;
				end
			end
			S_REL:    state_d = S_RN_CHK;
			S_RN_CHK: state_d = stat.idx1_lt_cnt ? S_RN_EV : S_RP_CHK;
			S_RN_EV: begin
				if (stat.rd_free) begin
					ret_d   = S_RN_CHK;
					state_d = S_MV_CHK;
				end else begin
					state_d = S_RP_CHK;
				end
			end
			S_RP_CHK: state_d = stat.idx_nz ? S_RP_EV : S_IDLE;
			S_RP_EV: begin
				if (stat.rd_free) begin
					ret_d   = S_DONE;
					state_d = S_MV_CHK;
				end else begin
					state_d = S_IDLE;
				end
			end
			S_MV_CHK: state_d = stat.ptr_lt_cnt ? S_MV_WR : ret_q;
			S_MV_WR:  state_d = S_MV_CHK;
			S_FIT_RD: state_d = stat.ptr_lt_cnt ? S_FIT_EV : S_IDLE;
			S_FIT_EV: state_d = stat.hit_fit ? S_FIT_GOT : S_FIT_RD;
			S_FIT_GOT: begin
				if (!stat.w_gt) begin
					state_d = S_FIT_END;
				end else if (stat.cnt_full) begin
					state_d = S_IDLE;
				end else begin
					ret_d   = S_FIT_END;
					state_d = S_SU_CHK;
				end
			end
			S_FIT_END: begin
				if (op_q == OP_MOVE_FIT) begin
					op_d    = OP_MOVE_FREE;
					state_d = S_FIND_RD;
				end else begin
					state_d = S_DONE;
				end
			end
			S_SU_CHK:  state_d = stat.ptr_gt_idx1 ? S_SU_WR : S_SP_TAIL;
			S_SU_WR:   state_d = S_SU_CHK;
			S_SP_TAIL: state_d = S_SP_HEAD;
			S_SP_HEAD: state_d = ret_q;
			S_RS_CHK: begin
				if (stat.w_free) begin
					state_d = S_IDLE;
				end else if (stat.w_eq) begin
					state_d = S_DONE;
				end else if (stat.w_gt) begin
					if (stat.cnt_full) begin
						state_d = S_IDLE;
					end else begin
						ret_d   = S_DONE;
						state_d = S_SU_CHK;
					end
				end else begin
					state_d = S_GR_CHK;
				end
			end
			S_GR_CHK: state_d = stat.idx1_lt_cnt ? S_GR_EV : S_MOVE;
			S_GR_EV: begin
				if (stat.absorb_ok) begin
					ret_d   = S_GR_POST;
					state_d = S_MV_CHK;
				end else begin
					state_d = S_MOVE;
				end
			end
			S_GR_POST: begin
				if (stat.w_gt) begin
					ret_d   = S_DONE;
					state_d = S_SU_CHK;
				end else begin
					state_d = S_IDLE;
				end
			end
			S_MOVE: begin
				op_d    = OP_MOVE_FIT;
				state_d = S_FIT_RD;
			end
			S_DONE:  state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd        = '0;
		cmd.ptr_op = P_HOLD;
		cmd.rd_sel = R_PTR;
		cmd.wr_op  = W_NONE;
		cmd.cnt_op = C_HOLD;
		cmd.w_op   = WO_HOLD;
		cmd.status = ST_OK;
		case (state_q)
			S_INIT: begin
				cmd.wr_op  = W_INIT;
				cmd.cnt_op = C_ONE;
			end
			S_IDLE: cmd.start = start && !cfg_we;
			S_DISPATCH: begin
				cmd.ptr_op = P_ZERO;
				case (stat.req_type)
					REQ_ALLOC, REQ_RESIZE: begin
						cmd.finish = stat.size_zero;
						cmd.status = ST_ZERO;
					end
					REQ_FREE: cmd.finish = 1'b0;
					default:  cmd.finish = 1'b1;
				endcase
			end
			S_FIND_RD: begin
				if (!stat.ptr_lt_cnt) begin
					cmd.finish = 1'b1;
					cmd.status = (op_q == OP_MOVE_FREE) ? ST_OK : ST_NOTFOUND;
				end
			end
			S_FIND_EV: begin
				if (stat.hit_find) begin
					cmd.w_op = WO_LD;
				end else begin
					cmd.ptr_op = P_INC;
				end
			end
			S_REL: begin
				cmd.w_op     = WO_FREE;
				cmd.res_addr = (op_q == OP_FREE);
			end
			S_RN_CHK: cmd.rd_sel = R_IDXP1;
			S_RN_EV: begin
				if (stat.rd_free) begin
					cmd.w_op   = WO_ABSORB;
					cmd.ptr_op = P_IDX2;
				end
			end
			S_RP_CHK: begin
				cmd.rd_sel = R_IDXM1;
				if (!stat.idx_nz) begin
					cmd.wr_op  = W_W;
					cmd.finish = 1'b1;
				end
			end
			S_RP_EV: begin
				if (stat.rd_free) begin
					cmd.wr_op  = W_PREV;
					cmd.ptr_op = P_IDX1;
				end else begin
					cmd.wr_op  = W_W;
					cmd.finish = 1'b1;
				end
			end
			S_MV_CHK: begin
				if (!stat.ptr_lt_cnt) begin
					cmd.cnt_op = C_DEC;
				end
			end
			S_MV_WR: begin
				cmd.wr_op  = W_PTRM1_RD;
				cmd.ptr_op = P_INC;
			end
			S_FIT_RD: begin
				if (!stat.ptr_lt_cnt) begin
					cmd.finish = 1'b1;
					cmd.status = ST_NOFIT;
				end
			end
			S_FIT_EV: begin
				if (stat.hit_fit) begin
					cmd.w_op = WO_LD;
				end else begin
					cmd.ptr_op = P_INC;
				end
			end
			S_FIT_GOT: begin
				if (!stat.w_gt) begin
					cmd.wr_op = W_HEAD;
				end else if (stat.cnt_full) begin
					cmd.finish = 1'b1;
					cmd.status = ST_FULL;
				end else begin
					cmd.ptr_op = P_CNT;
				end
			end
			S_FIT_END: begin
				cmd.res_woff  = 1'b1;
				cmd.set_reloc = (op_q == OP_MOVE_FIT);
				cmd.ptr_op    = P_ZERO;
			end
			S_SU_CHK: cmd.rd_sel = R_PTRM1;
			S_SU_WR: begin
				cmd.wr_op  = W_PTR_RD;
				cmd.ptr_op = P_DEC;
			end
			S_SP_TAIL: cmd.wr_op = W_TAIL;
			S_SP_HEAD: begin
				cmd.wr_op  = W_HEAD;
				cmd.cnt_op = C_INC;
			end
			S_RS_CHK: begin
				cmd.res_addr = 1'b1;
				if (stat.w_free) begin
					cmd.finish = 1'b1;
					cmd.status = ST_NOTFOUND;
				end else if (stat.w_gt) begin
					if (stat.cnt_full) begin
						cmd.finish = 1'b1;
						cmd.status = ST_FULL;
					end else begin
						cmd.ptr_op = P_CNT;
					end
				end
			end
			S_GR_CHK: cmd.rd_sel = R_IDXP1;
			S_GR_EV: begin
				if (stat.absorb_ok) begin
					cmd.w_op   = WO_ABSORB;
					cmd.ptr_op = P_IDX2;
				end
			end
			S_GR_POST: begin
				if (stat.w_gt) begin
					cmd.ptr_op = P_CNT;
				end else begin
					cmd.wr_op  = W_W;
					cmd.finish = 1'b1;
				end
			end
			S_MOVE: begin
				cmd.save_old = 1'b1;
				cmd.ptr_op   = P_ZERO;
			end
			S_DONE:  cmd.finish = 1'b1;
			default: cmd.finish = 1'b0;
		endcase
	end

endmodule

/* dv/testbench.sv */
`timescale 1ns / 1ps
// Self-checking testbench for first_fit_segment_allocator_core.
// Holds a segment-table predictor, a queued request driver and a result monitor.
// Depends on ffsa_pkg and the allocator RTL.
module testbench;
	import ffsa_pkg::*;

	typedef struct {
		logic [1:0]           kind;
		logic [ADDR_BITS-1:0] addr;
		logic [LEN_BITS-1:0]  size;
	} req_t;

	typedef struct {
		logic [2:0]           st;
		logic [ADDR_BITS-1:0] addr;
		logic                 moved;
		logic [ADDR_BITS-1:0] src;
		logic [LEN_BITS-1:0]  len;
	} rsp_t;

	localparam int WATCHDOG_LIMIT = 20000;

	logic                 clk = 0;
	logic                 arst_n = 0;
	logic                 start = 0;
	logic                 busy;
	logic [1:0]           req_type = '0;
	logic [ADDR_BITS-1:0] req_address = '0;
	logic [LEN_BITS-1:0]  req_size = '0;
	logic                 done;
	logic [2:0]           status;
	logic [ADDR_BITS-1:0] result_address;
	logic                 relocated;
	logic [ADDR_BITS-1:0] copy_from;
	logic [LEN_BITS-1:0]  copy_length;
	logic                 cfg_we = 0;
	logic [LEN_BITS-1:0]  cfg_wdata = '0;

	first_fit_segment_allocator_core u_top (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.req_type(req_type), .req_address(req_address), .req_size(req_size),
		.done(done), .status(status), .result_address(result_address),
		.relocated(relocated), .copy_from(copy_from), .copy_length(copy_length),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
	);

	// predictor state
	logic [LEN_BITS-1:0]  pool_bytes;
	logic [ADDR_BITS-1:0] tbl_off [MAX_SEGMENTS];
	logic [LEN_BITS-1:0]  tbl_len [MAX_SEGMENTS];
	logic                 tbl_free [MAX_SEGMENTS];
	int                   tbl_cnt;

	req_t pending_reqs[$];
	rsp_t expected_rsps[$];
	int   send_idle_pct = 17;
	int   mismatches = 0;
	int   results_seen = 0;
	int   reqs_sent = 0;
	int   quiet_cycles = 0;

	initial begin
		forever #6 clk = ~clk;
	end

	function automatic void table_reset(logic [LEN_BITS-1:0] v);
		logic [LEN_BITS-1:0] p;
		p = (v == 0) ? LEN_BITS'(1) : v;
		if (p > POOL_MAX) p = POOL_MAX;
		pool_bytes = p;
		tbl_off[0] = '0;
		tbl_len[0] = p;
		tbl_free[0] = 1;
		tbl_cnt = 1;
	endfunction

	function automatic int lookup(logic [ADDR_BITS-1:0] a);
		for (int i = 0; i < tbl_cnt; i++)
			if (tbl_off[i] == a) return i;
		return -1;
	endfunction

	function automatic void split_at(int i, logic [LEN_BITS-1:0] keep);
		for (int j = tbl_cnt; j > i + 1; j--) begin
			tbl_off[j] = tbl_off[j-1];
			tbl_len[j] = tbl_len[j-1];
			tbl_free[j] = tbl_free[j-1];
		end
		tbl_off[i+1] = tbl_off[i] + ADDR_BITS'(keep);
		tbl_len[i+1] = tbl_len[i] - keep;
		tbl_free[i+1] = 1;
		tbl_len[i] = keep;
		tbl_cnt++;
	endfunction

	function automatic void drop_entry(int i);
		for (int j = i; j < tbl_cnt - 1; j++) begin
			tbl_off[j] = tbl_off[j+1];
			tbl_len[j] = tbl_len[j+1];
			tbl_free[j] = tbl_free[j+1];
		end
		tbl_cnt--;
	endfunction

	function automatic logic [2:0] place_first_fit(logic [LEN_BITS-1:0] sz,
			output logic [ADDR_BITS-1:0] at);
		at = '0;
		for (int i = 0; i < tbl_cnt; i++)
			if (tbl_free[i] && tbl_len[i] >= sz) begin
				if (tbl_len[i] > sz) begin
					if (tbl_cnt >= MAX_SEGMENTS) return ST_FULL;
					split_at(i, sz);
				end
				tbl_free[i] = 0;
				at = tbl_off[i];
				return ST_OK;
			end
		return ST_NOFIT;
	endfunction

	function automatic void coalesce_free(int i);
		tbl_free[i] = 1;
		while (i + 1 < tbl_cnt && tbl_free[i+1]) begin
			tbl_len[i] += tbl_len[i+1];
			drop_entry(i + 1);
		end
		if (i > 0 && tbl_free[i-1]) begin
			tbl_len[i-1] += tbl_len[i];
			drop_entry(i);
		end
	endfunction

	function automatic rsp_t predict_allocator(req_t r);
		rsp_t o;
		int idx;
		logic [ADDR_BITS-1:0] fresh;
		logic [LEN_BITS-1:0] old_len;
		o = '{ST_OK, '0, 0, '0, '0};
		if (r.kind == REQ_ALLOC) begin
			if (r.size == 0) o.st = ST_ZERO;
			else o.st = place_first_fit(r.size, o.addr);
		end else if (r.kind == REQ_FREE) begin
			idx = lookup(r.addr);
			if (idx < 0) o.st = ST_NOTFOUND;
			else begin
				coalesce_free(idx);
				o.addr = r.addr;
			end
		end else if (r.kind == REQ_RESIZE) begin
			idx = lookup(r.addr);
			if (r.size == 0) o.st = ST_ZERO;
			else if (idx < 0 || tbl_free[idx]) o.st = ST_NOTFOUND;
			else if (tbl_len[idx] == r.size) o.addr = r.addr;
			else if (tbl_len[idx] > r.size) begin
				if (tbl_cnt >= MAX_SEGMENTS) o.st = ST_FULL;
				else begin
					split_at(idx, r.size);
					o.addr = r.addr;
				end
			end else if (idx + 1 < tbl_cnt && tbl_free[idx+1] &&
					tbl_len[idx] + tbl_len[idx+1] >= r.size) begin
				tbl_len[idx] += tbl_len[idx+1];
				drop_entry(idx + 1);
				if (tbl_len[idx] > r.size) split_at(idx, r.size);
				o.addr = r.addr;
			end else begin
				old_len = tbl_len[idx];
				o.st = place_first_fit(r.size, fresh);
				if (o.st == ST_OK) begin
					idx = lookup(r.addr);
					if (idx >= 0) coalesce_free(idx);
					o.addr = fresh;
					o.moved = 1;
					o.src = r.addr;
					o.len = old_len;
				end
			end
		end
		if (o.st != ST_OK) o.addr = '0;
		return o;
	endfunction

	// driver
	always @(posedge clk) begin
		logic took;
		took = start && !busy;
		if (arst_n) begin
			if (took) begin
				expected_rsps.push_back(predict_allocator(pending_reqs.pop_front()));
				reqs_sent++;
			end
			if (took || !start) begin
				if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
					start <= 1;
					req_type <= pending_reqs[0].kind;
					req_address <= pending_reqs[0].addr;
					req_size <= pending_reqs[0].size;
				end else
					start <= 0;
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		rsp_t e;
		if (arst_n && done) begin
			results_seen++;
			if (expected_rsps.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result, status %0d", status);
			end else begin
				e = expected_rsps.pop_front();
				if (status !== e.st || result_address !== e.addr || relocated !== e.moved ||
						copy_from !== e.src || copy_length !== e.len) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: exp st %0d addr %h rel %0d from %h len %h; got %0d %h %0d %h %h",
							e.st, e.addr, e.moved, e.src, e.len,
							status, result_address, relocated, copy_from, copy_length);
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || done || pending_reqs.size() == 0 && expected_rsps.size() == 0)
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("TEST FAILED");
				$finish;
			end
		end
	end

	function automatic logic [LEN_BITS-1:0] rand_size();
		case ($urandom_range(9))
			0: return LEN_BITS'($urandom_range(POOL_MAX));
			1: return '0;
			2, 3: return LEN_BITS'($urandom_range(4096, 1));
			default: return LEN_BITS'($urandom_range(pool_bytes / 8 + 1, 1));
		endcase
	endfunction

	// address drawn from the live model, so most frees and resizes hit
	function automatic logic [ADDR_BITS-1:0] rand_addr();
		if ($urandom_range(9) < 8) return tbl_off[$urandom_range(tbl_cnt - 1)];
		return ADDR_BITS'($urandom);
	endfunction

	task automatic drain();
		while (pending_reqs.size() != 0 || expected_rsps.size() != 0 || start)
			@(posedge clk);
		repeat (900) @(posedge clk);
	endtask

	task automatic write_pool(logic [LEN_BITS-1:0] v);
		@(posedge clk);
		cfg_we <= 1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 0;
		table_reset(v);
		repeat (3) @(posedge clk);
	endtask

	task automatic push_req(logic [1:0] k, logic [ADDR_BITS-1:0] a, logic [LEN_BITS-1:0] s);
		pending_reqs.push_back('{k, a, s});
	endtask

	// random phase; the shadow model supplies the addresses and predicts every result
	task automatic random_phase(int n);
		logic [1:0] k;
		for (int i = 0; i < n; i++) begin
			while (pending_reqs.size() >= 2)
				@(posedge clk);
			k = ($urandom_range(99) < 2) ? 2'd3 : 2'($urandom_range(2));
			push_req(k, rand_addr(), rand_size());
			if (k == 2'd3) i--;
			@(posedge clk);
		end
		drain();
	endtask

	initial begin
		table_reset(POOL_MAX);
		repeat (11) @(posedge clk);
		arst_n <= 1;
		repeat (3) @(posedge clk);

		push_req(REQ_ALLOC, '0, '0);
		push_req(REQ_ALLOC, '0, 17'd100);
		push_req(REQ_ALLOC, '0, 17'd200);
		push_req(REQ_ALLOC, '0, POOL_MAX);
		push_req(REQ_RESIZE, 16'd0, 17'd100);
		push_req(REQ_RESIZE, 16'd0, 17'd50);
		push_req(REQ_RESIZE, 16'd100, 17'd300);
		push_req(REQ_RESIZE, 16'd0, 17'd1000);
		push_req(REQ_RESIZE, 16'd50, 17'd10);
		push_req(REQ_RESIZE, 16'd0, '0);
		push_req(REQ_RESIZE, 16'hFFFF, 17'd5);
		push_req(REQ_FREE, 16'hFFFF, '0);
		push_req(REQ_FREE, 16'd100, '0);
		push_req(REQ_FREE, 16'd100, '0);
		push_req(2'd3, 16'hFFFF, 17'h1FFFF);
		push_req(REQ_ALLOC, '0, 17'h1FFFF);
		drain();

		write_pool(17'd64);
		for (int i = 0; i < 66; i++) push_req(REQ_ALLOC, '0, 17'd1);
		push_req(REQ_RESIZE, 16'd0, 17'd1);
		push_req(REQ_FREE, 16'd2, '0);
		push_req(REQ_FREE, 16'd3, '0);
		drain();
		write_pool(17'd100);
		for (int i = 0; i < 64; i++) push_req(REQ_ALLOC, '0, 17'd1);
		push_req(REQ_RESIZE, 16'd0, 17'd2);
		push_req(REQ_RESIZE, 16'd1, 17'd3);
		drain();

		send_idle_pct = 17;
		write_pool('0);
		push_req(REQ_ALLOC, '0, 17'd1);
		push_req(REQ_ALLOC, '0, 17'd1);
		drain();
		write_pool(17'h1FFFF);
		random_phase(600);
		send_idle_pct = 85;
		write_pool(17'd4096);
		random_phase(400);
		send_idle_pct = 0;
		write_pool(17'd512);
		random_phase(450);
		write_pool(POOL_MAX);
		random_phase(300);

		$display("Covered %0d requests over pools of 1, 64, 100, 512, 4096 and 65536 bytes",
			reqs_sent);
		$display("plus an over-range write; %0d results checked incl. full-table and moves.",
			results_seen);
		if (mismatches == 0 && expected_rsps.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end
endmodule
